// ===== rtl/cta_pkg.sv =====
// ----------------------------------------------------------------------------
// cta_pkg
// Shared types, codes and constants of the camera target alignment qualifier.
// ----------------------------------------------------------------------------
package cta_pkg;

  localparam logic [7:0]  KIND_BLOB   = 8'h01 << 0;
  localparam logic [7:0]  KIND_RING   = 8'h01 << 4;
  localparam logic [3:0]  BLOB_DWELL  = 4'd3;
  localparam logic [3:0]  RING_DWELL  = 4'd3;
  localparam logic [15:0] STILL_LIMIT = 16'd5;

  localparam int IN_W  = 40;
  localparam int OUT_W = 48;

  typedef enum logic [1:0] {
    MODE_BLOB_CAL  = 2'd0,
    MODE_BLOB_GRAB = 2'd1,
    MODE_RING_CAL  = 2'd2,
    MODE_IDLE      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_ALIGNED = 2'd1,
    EV_CORRECT = 2'd2
  } evt_code_t;

  typedef enum logic [2:0] {
    REG_MODE            = 3'd0,
    REG_BLOB_CENTRE_X   = 3'd1,
    REG_BLOB_CENTRE_Y   = 3'd2,
    REG_BLOB_TOL_FINE   = 3'd3,
    REG_BLOB_TOL_COARSE = 3'd4,
    REG_RING_CENTRE_X   = 3'd5,
    REG_RING_CENTRE_Y   = 3'd6,
    REG_RING_TOL        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] blob_centre_x;
    logic [15:0] blob_centre_y;
    logic [7:0]  blob_tol_fine;
    logic [7:0]  blob_tol_coarse;
    logic [15:0] ring_centre_x;
    logic [15:0] ring_centre_y;
    logic [7:0]  ring_tol;
  } cfg_t;

  typedef struct packed {
    evt_code_t   evt;
    logic        dir_x;
    logic [15:0] mag_x;
    logic        dir_y;
    logic [15:0] mag_y;
  } cmd_t;

  function automatic logic [15:0] absdiff16(input logic [15:0] a, input logic [15:0] b);
    absdiff16 = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/cta_regs.sv =====
// ----------------------------------------------------------------------------
// cta_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module cta_regs
  import cta_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= MODE_IDLE;
      cfg.blob_centre_x   <= 16'd175;
      cfg.blob_centre_y   <= 16'd110;
      cfg.blob_tol_fine   <= 8'd10;
      cfg.blob_tol_coarse <= 8'd30;
      cfg.ring_centre_x   <= 16'd138;
      cfg.ring_centre_y   <= 16'd108;
      cfg.ring_tol        <= 8'd1;
    end else if (wr) begin
      case (idx)
        REG_MODE:            cfg.mode            <= mode_t'(pwdata[1:0]);
        REG_BLOB_CENTRE_X:   cfg.blob_centre_x   <= pwdata[15:0];
        REG_BLOB_CENTRE_Y:   cfg.blob_centre_y   <= pwdata[15:0];
        REG_BLOB_TOL_FINE:   cfg.blob_tol_fine   <= pwdata[7:0];
        REG_BLOB_TOL_COARSE: cfg.blob_tol_coarse <= pwdata[7:0];
        REG_RING_CENTRE_X:   cfg.ring_centre_x   <= pwdata[15:0];
        REG_RING_CENTRE_Y:   cfg.ring_centre_y   <= pwdata[15:0];
        REG_RING_TOL:        cfg.ring_tol        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:            prdata = {30'd0, cfg.mode};
      REG_BLOB_CENTRE_X:   prdata = {16'd0, cfg.blob_centre_x};
      REG_BLOB_CENTRE_Y:   prdata = {16'd0, cfg.blob_centre_y};
      REG_BLOB_TOL_FINE:   prdata = {24'd0, cfg.blob_tol_fine};
      REG_BLOB_TOL_COARSE: prdata = {24'd0, cfg.blob_tol_coarse};
      REG_RING_CENTRE_X:   prdata = {16'd0, cfg.ring_centre_x};
      REG_RING_CENTRE_Y:   prdata = {16'd0, cfg.ring_centre_y};
      REG_RING_TOL:        prdata = {24'd0, cfg.ring_tol};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/cta_front.sv =====
// ----------------------------------------------------------------------------
// cta_front
// Accepts camera reports, classifies them by mode and updates the dwell and
// last-position state; emits one command per report.
// ----------------------------------------------------------------------------
module cta_front
  import cta_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        fire,
  input  logic [7:0]  report_kind,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  output cmd_t        cmd
);

  logic [15:0] last_x, last_y, last_x_next, last_y_next;
  logic [3:0]  dwell_count, dwell_count_next;

  logic        still;
  logic [3:0]  blob_step;
  logic [16:0] sum_x, sum_y, twoc_x, twoc_y, hdiff_x, hdiff_y;
  logic        hdir_x, hdir_y;
  logic        fine_in, coarse_in, ring_in;

  assign still = (absdiff16(pos_x, last_x) < STILL_LIMIT) &&
                 (absdiff16(pos_y, last_y) < STILL_LIMIT);
  assign blob_step = !still ? 4'd0 :
                     (dwell_count < BLOB_DWELL) ? dwell_count + 4'd1 : dwell_count;

  assign sum_x   = {1'b0, pos_x} + {1'b0, last_x};
  assign sum_y   = {1'b0, pos_y} + {1'b0, last_y};
  assign twoc_x  = {cfg.blob_centre_x, 1'b0};
  assign twoc_y  = {cfg.blob_centre_y, 1'b0};
  assign hdir_x  = sum_x < twoc_x;
  assign hdir_y  = sum_y < twoc_y;
  assign hdiff_x = hdir_x ? twoc_x - sum_x : sum_x - twoc_x;
  assign hdiff_y = hdir_y ? twoc_y - sum_y : sum_y - twoc_y;

  assign fine_in   = (absdiff16(pos_x, cfg.blob_centre_x) <= {8'd0, cfg.blob_tol_fine}) &&
                     (absdiff16(pos_y, cfg.blob_centre_y) <= {8'd0, cfg.blob_tol_fine});
  assign coarse_in = (absdiff16(pos_x, cfg.blob_centre_x) <= {8'd0, cfg.blob_tol_coarse}) &&
                     (absdiff16(pos_y, cfg.blob_centre_y) <= {8'd0, cfg.blob_tol_coarse});
  assign ring_in   = (absdiff16(pos_x, cfg.ring_centre_x) <= {8'd0, cfg.ring_tol}) &&
                     (absdiff16(pos_y, cfg.ring_centre_y) <= {8'd0, cfg.ring_tol});

  always_comb begin
    cmd              = '0;
    cmd.evt          = EV_NONE;
    last_x_next      = last_x;
    last_y_next      = last_y;
    dwell_count_next = dwell_count;
    case (cfg.mode)
      MODE_BLOB_CAL: begin
        if (report_kind == KIND_BLOB) begin
          dwell_count_next = blob_step;
          if (blob_step >= BLOB_DWELL) begin
            dwell_count_next = 4'd0;
            if (fine_in) begin
              cmd.evt = EV_ALIGNED;
            end else begin
              cmd.evt   = EV_CORRECT;
              cmd.dir_x = hdir_x;
              cmd.mag_x = hdiff_x[16:1];
              cmd.dir_y = hdir_y;
              cmd.mag_y = hdiff_y[16:1];
            end
          end
          last_x_next = pos_x;
          last_y_next = pos_y;
        end
      end
      MODE_BLOB_GRAB: begin
        if (report_kind == KIND_BLOB && coarse_in) begin
          cmd.evt = EV_ALIGNED;
        end
      end
      MODE_RING_CAL: begin
        if (report_kind == KIND_RING) begin
          if (ring_in) begin
            if (dwell_count < RING_DWELL) begin
              dwell_count_next = dwell_count + 4'd1;
            end else begin
              cmd.evt          = EV_ALIGNED;
              dwell_count_next = 4'd0;
            end
          end else begin
            dwell_count_next = 4'd0;
            cmd.evt          = EV_CORRECT;
            cmd.dir_x        = pos_x < cfg.ring_centre_x;
            cmd.mag_x        = absdiff16(pos_x, cfg.ring_centre_x);
            cmd.dir_y        = pos_y < cfg.ring_centre_y;
            cmd.mag_y        = absdiff16(pos_y, cfg.ring_centre_y);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x      <= 16'd0;
      last_y      <= 16'd0;
      dwell_count <= 4'd0;
    end else if (fire) begin
      last_x      <= last_x_next;
      last_y      <= last_y_next;
      dwell_count <= dwell_count_next;
    end
  end

endmodule

// ===== rtl/cta_queue.sv =====
// ----------------------------------------------------------------------------
// cta_queue
// Short command queue between the classifier and the result stage.
// ----------------------------------------------------------------------------
module cta_queue
  import cta_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic not_empty
);

  localparam int DEPTH = 4;

  cmd_t       mem [DEPTH];
  logic [1:0] wptr, rptr;
  logic [2:0] count;
  logic       do_push, do_pop;

  assign full      = count == 3'(DEPTH);
  assign not_empty = count != 3'd0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 2'd1;
      end
      if (do_pop) begin
        rptr <= rptr + 2'd1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/cta_back.sv =====
// ----------------------------------------------------------------------------
// cta_back
// Scales correction magnitudes by ten and holds the result in the output
// register until the transfer completes.
// ----------------------------------------------------------------------------
module cta_back
  import cta_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata
);

  logic [19:0] move_x, move_y;
  logic        load;

  assign move_x  = {1'b0, cmd.mag_x, 3'b000} + {3'b000, cmd.mag_x, 1'b0};
  assign move_y  = {1'b0, cmd.mag_y, 3'b000} + {3'b000, cmd.mag_y, 1'b0};
  assign load    = cmd_valid && (!m_tvalid || m_tready);
  assign cmd_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {4'd0, move_y, cmd.dir_y, move_x, cmd.dir_x, cmd.evt};
    end
  end

endmodule

// ===== rtl/camera_target_alignment_qualifier.sv =====
// ----------------------------------------------------------------------------
// camera_target_alignment_qualifier
// Checks camera target reports against a configured centre and issues
// aligned events or position corrections.
// ----------------------------------------------------------------------------
// Every accepted report yields exactly one result. One report is accepted per
// clock cycle; a result passes through the command queue and the output register.
// The classifier decides each report in the cycle it is accepted, a four-entry
// command queue decouples it from the result register, and reports are held
// off only when that queue is full. Configure only while no report is in
// flight.
module camera_target_alignment_qualifier
  import cta_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // report_kind[7:0], pos_x[23:8], pos_y[39:24]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // event_res[1:0], dir_x[2], move_x[22:3],
                                       // dir_y[23], move_y[43:24], zero[47:44]
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t front_cmd, queue_cmd;
  logic q_full, q_not_empty, q_pop, fire;

  assign s_tready = !q_full;
  assign fire     = s_tvalid && s_tready;

  cta_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cta_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .fire        (fire),
    .report_kind (s_tdata[7:0]),
    .pos_x       (s_tdata[23:8]),
    .pos_y       (s_tdata[39:24]),
    .cmd         (front_cmd)
  );

  cta_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (queue_cmd),
    .not_empty (q_not_empty)
  );

  cta_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (queue_cmd),
    .cmd_pop   (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
